>>> sv/wavhp_pkg.sv
// wavhp_pkg: types, constants and tag lookup for the wav header parser
// no dependencies; imported by every module of the block

package wavhp_pkg;

  localparam int HEADER_BYTES = 44;
  localparam int OFF_W        = 6;
  localparam logic [OFF_W-1:0] LAST_OFFSET = OFF_W'(HEADER_BYTES - 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int DIVISOR_W = 29;
  localparam int QUOT_W    = 32;
  localparam int STEP_W    = $clog2(QUOT_W);

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_RIFF = 3'd1;
  localparam logic [2:0] ST_BAD_WAVE = 3'd2;
  localparam logic [2:0] ST_BAD_FMT  = 3'd3;
  localparam logic [2:0] ST_NOT_PCM  = 3'd4;
  localparam logic [2:0] ST_BAD_DATA = 3'd5;

  localparam logic [15:0] PCM_FORMAT = 16'h0001;
  localparam logic [15:0] DEPTH_8BIT = 16'd8;
  localparam logic [15:0] STEREO     = 16'd2;

  localparam logic [31:0] TAG_RIFF = "RIFF";
  localparam logic [31:0] TAG_WAVE = "WAVE";
  localparam logic [31:0] TAG_FMT  = "fmt ";
  localparam logic [31:0] TAG_DATA = "data";

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_flag;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] chunk_size;
    logic [31:0] fmt_size;
    logic [15:0] audio_format;
    logic [15:0] num_channels;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] bits_per_sample;
    logic [31:0] data_size;
    logic [31:0] num_samples;
    logic [2:0]  sample_repeat;
  } out_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] chunk_size;
    logic [31:0] fmt_size;
    logic [15:0] audio_format;
    logic [15:0] num_channels;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] bits_per_sample;
    logic [31:0] data_size;
  } hdr_t;

  typedef struct packed {
    logic full;
    hdr_t hdr;
  } job_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] status;
    logic [7:0] value;
  } tag_t;

  function automatic tag_t tag_lookup(input logic [OFF_W-1:0] off);
    tag_t t;
    logic [4:0] sh;
    sh = 5'(8 * (3 - int'(off[1:0])));
    t = '0;
    case (off) inside
      [6'd0:6'd3]: begin
        t.hit = 1'b1;
        t.status = ST_BAD_RIFF;
        t.value = 8'(TAG_RIFF >> sh);
      end
      [6'd8:6'd11]: begin
        t.hit = 1'b1;
        t.status = ST_BAD_WAVE;
        t.value = 8'(TAG_WAVE >> sh);
      end
      [6'd12:6'd15]: begin
        t.hit = 1'b1;
        t.status = ST_BAD_FMT;
        t.value = 8'(TAG_FMT >> sh);
      end
      [6'd36:6'd39]: begin
        t.hit = 1'b1;
        t.status = ST_BAD_DATA;
        t.value = 8'(TAG_DATA >> sh);
      end
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

>>> sv/wavhp_front.sv
// wavhp_front: byte parser, tag and format checks, little-endian field capture
// depends on wavhp_pkg; pushes one job per header into the queue

module wavhp_front
  import wavhp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic byte_valid,
  output logic byte_stall,
  input  in_t  byte_data,
  output logic push,
  output job_t push_data,
  input  logic q_full
);

  logic [OFF_W-1:0] byte_offset;
  logic             halted;
  hdr_t             fld;

  logic             accept;
  logic             run;
  logic [OFF_W-1:0] off;
  logic [7:0]       b;
  hdr_t             base;
  hdr_t             fld_next;
  tag_t             tag;
  logic             emit;
  logic             full;
  logic [2:0]       status;

  assign byte_stall = q_full;
  assign accept     = byte_valid && !byte_stall;
  assign b          = byte_data.data_byte;
  assign off        = byte_data.start_flag ? '0 : byte_offset;
  assign base       = byte_data.start_flag ? '0 : fld;
  assign run        = accept && (byte_data.start_flag || !halted);
  assign tag        = tag_lookup(off);

  always_comb begin
    fld_next = base;
    case (off) inside
      [6'd4:6'd7]:   fld_next.chunk_size[8*off[1:0] +: 8] = b;
      [6'd16:6'd19]: fld_next.fmt_size[8*off[1:0] +: 8] = b;
      [6'd20:6'd21]: fld_next.audio_format[8*off[0] +: 8] = b;
      [6'd22:6'd23]: fld_next.num_channels[8*off[0] +: 8] = b;
      [6'd24:6'd27]: fld_next.sample_rate[8*off[1:0] +: 8] = b;
      [6'd28:6'd31]: fld_next.byte_rate[8*off[1:0] +: 8] = b;
      [6'd34:6'd35]: fld_next.bits_per_sample[8*off[0] +: 8] = b;
      [6'd40:6'd43]: fld_next.data_size[8*off[1:0] +: 8] = b;
      default: ;
    endcase
  end

  always_comb begin
    emit   = 1'b0;
    full   = 1'b0;
    status = ST_OK;
    if (tag.hit && b != tag.value) begin
      emit   = 1'b1;
      status = tag.status;
    end else if (off == 6'd21 && fld_next.audio_format != PCM_FORMAT) begin
      emit   = 1'b1;
      status = ST_NOT_PCM;
    end else if (off == LAST_OFFSET) begin
      emit   = 1'b1;
      full   = 1'b1;
    end
  end

  always_comb begin
    push_data            = '0;
    push_data.full       = full;
    push_data.hdr        = fld_next;
    push_data.hdr.status = status;
  end

  assign push = run && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
      halted      <= 1'b1;
    end else if (run) begin
      if (emit) begin
        halted      <= 1'b1;
        byte_offset <= '0;
      end else begin
        halted      <= 1'b0;
        byte_offset <= off + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      fld <= fld_next;
    end
  end

endmodule

>>> sv/wavhp_queue.sv
// wavhp_queue: short job queue between the byte parser and the divider
// depends on wavhp_pkg for job_t and the queue depth

module wavhp_queue
  import wavhp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t pop_data
);

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = count == QCNT_W'(QUEUE_DEPTH);
  assign valid    = count != '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !valid))
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

>>> sv/wavhp_back.sv
// wavhp_back: sample count by serial restoring division, repeat code, result register
// depends on wavhp_pkg; pops jobs from wavhp_queue

module wavhp_back
  import wavhp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  job_t q_data,
  output logic pop,
  output logic result_valid,
  input  logic result_stall,
  output out_t result_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]           state;
  hdr_t                 job;
  logic [2:0]           rep;
  logic [DIVISOR_W-1:0] divisor;
  logic [QUOT_W-1:0]    quo;
  logic [DIVISOR_W-1:0] rem;
  logic [STEP_W-1:0]    step;

  logic [DIVISOR_W:0]   rem_sh;
  logic                 fits;
  logic [2:0]           rep_calc;
  logic                 load;

  assign rem_sh = {rem, quo[QUOT_W-1]};
  assign fits   = rem_sh >= {1'b0, divisor};
  assign pop    = state == S_IDLE && q_valid;
  assign load   = state == S_DONE && (!result_valid || !result_stall);

  always_comb begin
    if (q_data.hdr.num_channels == STEREO) begin
      rep_calc = (q_data.hdr.bits_per_sample == DEPTH_8BIT) ? 3'd2 : 3'd4;
    end else begin
      rep_calc = (q_data.hdr.bits_per_sample == DEPTH_8BIT) ? 3'd1 : 3'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= q_data.full ? S_MUL : S_DONE;
          end
        end
        S_MUL: state <= S_DIV;
        S_DIV: begin
          if (divisor == '0 || step == STEP_W'(QUOT_W - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          job <= q_data.hdr;
          rep <= q_data.full ? rep_calc : 3'd1;
          quo <= q_data.full ? q_data.hdr.data_size : '0;
          rem <= '0;
        end
      end
      S_MUL: begin
        divisor <= DIVISOR_W'(job.num_channels) * DIVISOR_W'(job.bits_per_sample[15:3]);
        step    <= '0;
      end
      S_DIV: begin
        if (divisor == '0) begin
          quo <= '0;
        end else begin
          quo  <= {quo[QUOT_W-2:0], fits};
          rem  <= fits ? DIVISOR_W'(rem_sh - {1'b0, divisor}) : rem_sh[DIVISOR_W-1:0];
          step <= step + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_data.status          <= job.status;
      result_data.chunk_size      <= job.chunk_size;
      result_data.fmt_size        <= job.fmt_size;
      result_data.audio_format    <= job.audio_format;
      result_data.num_channels    <= job.num_channels;
      result_data.sample_rate     <= job.sample_rate;
      result_data.byte_rate       <= job.byte_rate;
      result_data.bits_per_sample <= job.bits_per_sample;
      result_data.data_size       <= job.data_size;
      result_data.num_samples     <= quo;
      result_data.sample_repeat   <= rep;
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst) pop |-> state == S_IDLE)
    else $error("job popped while busy");
  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |=> state == S_DIV || state == S_DONE)
    else $error("divider left to wrong state");
  a_step_adv: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && divisor != '0 && step != STEP_W'(QUOT_W - 1)
    |=> step == $past(step) + 1'b1)
    else $error("division step did not advance");
  a_fail_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.status != ST_OK
    |-> result_data.num_samples == '0 && result_data.sample_repeat == 3'd1)
    else $error("failure result carries computed fields");

endmodule

>>> sv/wav_header_parser.sv
// wav_header_parser: top level of the canonical wav header parser
// depends on wavhp_pkg, wavhp_front, wavhp_queue and wavhp_back
//
//   channel   signals                                 payload
//   byte      byte_valid, byte_stall, byte_data       in_t  (data_byte, start_flag)
//   result    result_valid, result_stall, result_data out_t (status, fields, count)
//
// one header byte per cycle; byte_stall rises only when the two-entry job queue is full
// a full header takes the back end through pop, multiply, 32 divide steps and load, a
// zero divisor ends the divide at its first step, so 44-byte headers stream without
// stalls; a failure skips multiply and divide and goes from pop straight to load
// synchronous reset clears the queue and the parser, which then waits for start_flag
// a held result_stall fills the queue and then stalls the byte side

module wav_header_parser
  import wavhp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic byte_valid,
  output logic byte_stall,
  input  in_t  byte_data,
  output logic result_valid,
  input  logic result_stall,
  output out_t result_data
);

  logic push;
  job_t push_data;
  logic q_full;
  logic pop;
  logic q_valid;
  job_t q_data;

  wavhp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .push       (push),
    .push_data  (push_data),
    .q_full     (q_full)
  );

  wavhp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .valid     (q_valid),
    .pop_data  (q_data)
  );

  wavhp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule
